@@ rtl/core/bchd_pkg.sv @@
// ----------------------------------------------------------------------------
// bchd_pkg
// Shared types and constants for the button click / hold detector: event
// codes, register indexes, per-button state record and reset values.
// ----------------------------------------------------------------------------
package bchd_pkg;

   localparam int BTN_CNT   = 8;
   localparam int IDX_W     = 3;
   localparam int TIME_W    = 32;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [CFG_W-1:0] GAP_RESET      = 16'd250;
   localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd1000;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_HOLD   = 2'd3
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_GAP      = 2'd1,
      CSR_HOLD     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] double_click_gap_ms;
      logic [CFG_W-1:0] hold_ms;
   } cfg_type;

   typedef struct packed {
      logic              last_level;
      logic              waiting_double;
      logic              double_on_release;
      logic              single_allowed;
      logic [TIME_W-1:0] press_time;
      logic [TIME_W-1:0] release_time;
      logic              ignore_release;
      logic              hold_done;
   } btn_state_type;

   localparam btn_state_type BTN_STATE_RESET = '{
      last_level:        1'b0,
      waiting_double:    1'b0,
      double_on_release: 1'b0,
      single_allowed:    1'b1,
      press_time:        {TIME_W{1'b1}},
      release_time:      {TIME_W{1'b1}},
      ignore_release:    1'b0,
      hold_done:         1'b0
   };

endpackage

@@ rtl/core/bchd_eval.sv @@
// ----------------------------------------------------------------------------
// bchd_eval
// Next-state and event logic for one poll sample of one button: debounced
// edges, double click, single click after the gap, and one hold per press.
// ----------------------------------------------------------------------------
module bchd_eval (
   input  bchd_pkg::cfg_type                cfg,
   input  bchd_pkg::btn_state_type          cur,
   input  logic                             level,
   input  logic [bchd_pkg::TIME_W-1:0]      now_ms,
   output bchd_pkg::btn_state_type          nxt,
   output bchd_pkg::event_type              event_code
);

   logic [bchd_pkg::TIME_W-1:0] d_rel;
   logic [bchd_pkg::TIME_W-1:0] d_prs;
   logic [bchd_pkg::TIME_W-1:0] d_rel2;
   logic [bchd_pkg::TIME_W-1:0] d_prs2;
   logic [bchd_pkg::TIME_W-1:0] deb_w;
   logic [bchd_pkg::TIME_W-1:0] gap_w;
   logic [bchd_pkg::TIME_W-1:0] hold_w;
   logic                        rel_upd;
   logic                        prs_upd;

   assign deb_w  = {{(bchd_pkg::TIME_W-bchd_pkg::CFG_W){1'b0}}, cfg.debounce_ms};
   assign gap_w  = {{(bchd_pkg::TIME_W-bchd_pkg::CFG_W){1'b0}}, cfg.double_click_gap_ms};
   assign hold_w = {{(bchd_pkg::TIME_W-bchd_pkg::CFG_W){1'b0}}, cfg.hold_ms};
   assign d_rel  = now_ms - cur.release_time;
   assign d_prs  = now_ms - cur.press_time;

   always_comb begin
      nxt        = cur;
      event_code = bchd_pkg::EV_NONE;
      rel_upd    = 1'b0;
      prs_upd    = 1'b0;

      // debounced edges
      if (level && !cur.last_level && (d_rel > deb_w)) begin
         prs_upd               = 1'b1;
         nxt.press_time        = now_ms;
         nxt.ignore_release    = 1'b0;
         nxt.single_allowed    = 1'b1;
         nxt.hold_done         = 1'b0;
         nxt.double_on_release = (d_rel < gap_w) && !cur.double_on_release
                                 && cur.waiting_double;
         nxt.waiting_double    = 1'b0;
      end else if (!level && cur.last_level && (d_prs > deb_w)) begin
         if (!cur.ignore_release) begin
            rel_upd          = 1'b1;
            nxt.release_time = now_ms;
            if (!cur.double_on_release) begin
               nxt.waiting_double = 1'b1;
            end else begin
               event_code            = bchd_pkg::EV_DOUBLE;
               nxt.double_on_release = 1'b0;
               nxt.waiting_double    = 1'b0;
               nxt.single_allowed    = 1'b0;
            end
         end
      end

      d_rel2 = rel_upd ? '0 : d_rel;
      d_prs2 = prs_upd ? '0 : d_prs;

      // single click once the gap has run out
      if (!level && (d_rel2 >= gap_w) && nxt.waiting_double && !nxt.double_on_release
          && nxt.single_allowed && (event_code != bchd_pkg::EV_DOUBLE)) begin
         event_code         = bchd_pkg::EV_CLICK;
         nxt.waiting_double = 1'b0;
      end

      // hold, once per press
      if (level && (d_prs2 >= hold_w) && !nxt.hold_done) begin
         event_code            = bchd_pkg::EV_HOLD;
         nxt.ignore_release    = 1'b1;
         nxt.double_on_release = 1'b0;
         nxt.waiting_double    = 1'b0;
         nxt.hold_done         = 1'b1;
      end

      nxt.last_level = level;
   end

endmodule

@@ rtl/core/button_click_hold_detector_core.sv @@
// ----------------------------------------------------------------------------
// button_click_hold_detector_core
// Per-button click, double click and hold detection from poll samples.
// ----------------------------------------------------------------------------
// Takes one poll sample per clock cycle while the result is not stalled. A
// sample is captured in an input register and evaluated in the next cycle
// against its button's state, which is written back as the sample advances,
// so samples for the same button may follow each other without gaps; the
// result beat is registered on advance, and every sample gives one. The
// per-button state sits in flip-flops that reset sets at once, so there is
// no start-up pass. Samples for a button index at or above the button count
// give no event and change nothing. Registers are written through the csr
// port, which is always ready; writes to an unknown index are dropped.
module button_click_hold_detector_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bchd_pkg::IDX_W-1:0]           req_button_index,
   input  logic                                 req_level,
   input  logic [bchd_pkg::TIME_W-1:0]          req_now_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_event_code,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bchd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bchd_pkg::CFG_W-1:0]           csr_wdata
);

   bchd_pkg::cfg_type           cfg_ff;
   bchd_pkg::cfg_type           cfg_in;
   bchd_pkg::btn_state_type     state_ff [bchd_pkg::BTN_CNT];
   bchd_pkg::btn_state_type     cur_state;
   bchd_pkg::btn_state_type     nxt_state;
   bchd_pkg::event_type         ev;

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [bchd_pkg::IDX_W-1:0]  in_idx_ff;
   logic                        in_level_ff;
   logic [bchd_pkg::TIME_W-1:0] in_now_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [1:0]                  rsp_code_ff;
   logic                        advance;
   logic                        take;
   logic                        in_range;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (bchd_pkg::csr_index_type'(csr_index))
            bchd_pkg::CSR_DEBOUNCE: cfg_in.debounce_ms         = csr_wdata;
            bchd_pkg::CSR_GAP:      cfg_in.double_click_gap_ms = csr_wdata;
            bchd_pkg::CSR_HOLD:     cfg_in.hold_ms             = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms         <= bchd_pkg::DEBOUNCE_RESET;
         cfg_ff.double_click_gap_ms <= bchd_pkg::GAP_RESET;
         cfg_ff.hold_ms             <= bchd_pkg::HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign take         = req_valid && !req_stall;
   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_idx_ff   <= req_button_index;
         in_level_ff <= req_level;
         in_now_ff   <= req_now_ms;
      end
      if (advance) begin
         rsp_code_ff <= in_range ? ev : bchd_pkg::EV_NONE;
      end
   end

   // per-button state
   assign in_range  = ({1'b0, in_idx_ff} < (bchd_pkg::IDX_W+1)'(bchd_pkg::BTN_CNT));
   assign cur_state = state_ff[in_idx_ff];

   bchd_eval u_eval (
      .cfg        (cfg_ff),
      .cur        (cur_state),
      .level      (in_level_ff),
      .now_ms     (in_now_ff),
      .nxt        (nxt_state),
      .event_code (ev)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < bchd_pkg::BTN_CNT; b++) begin
            state_ff[b] <= bchd_pkg::BTN_STATE_RESET;
         end
      end else if (advance && in_range) begin
         state_ff[in_idx_ff] <= nxt_state;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_code_ff;

endmodule

@@ rtl/core/bchd_checker.sv @@
// ----------------------------------------------------------------------------
// bchd_checker
// Port-level checks for the button click / hold detector, bound to the top.
// ----------------------------------------------------------------------------
module bchd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [bchd_pkg::IDX_W-1:0]           req_button_index,
   input logic                                 req_level,
   input logic [bchd_pkg::TIME_W-1:0]          req_now_ms,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [1:0]                           rsp_event_code,
   input logic                                 csr_valid,
   input logic                                 csr_ready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code))
      else $error("result beat changed while stalled");

   // a stalled poll beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_button_index)
         && $stable(req_level) && $stable(req_now_ms))
      else $error("poll beat changed while stalled");

   // nothing in flight straight after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // input only stalls behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without backpressure");

   // config port never blocks
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write refused");

endmodule

bind button_click_hold_detector_core bchd_checker u_bchd_checker (.*);
